[design/twp_pkg.sv]
// Shared types, field widths and the signed three-way compare for the
// three-way pivot partition unit. No dependencies.

package twp_pkg;

  localparam int VALUE_W    = 32;
  localparam int REGION_W   = 2;
  localparam int POSITION_W = 4;
  localparam int TOTAL_W    = 5;
  localparam int OUT_DATA_W = 48;

  // Class of an element relative to the pivot
  typedef enum logic [REGION_W-1:0] {
    REGION_SMALLER = 2'd0,
    REGION_EQUAL   = 2'd1,
    REGION_BIGGER  = 2'd2
  } region_t;

  // Signed compare of an element against the pivot
  function automatic region_t classify(input logic [VALUE_W-1:0] value,
                                       input logic [VALUE_W-1:0] pivot);
    region_t r;
    if ($signed(value) < $signed(pivot)) begin
      r = REGION_SMALLER;
    end else if (value == pivot) begin
      r = REGION_EQUAL;
    end else begin
      r = REGION_BIGGER;
    end
    return r;
  endfunction

endpackage

[design/twp_store.sv]
// Element store: single write port, single read port, registered read.
// Depends on twp_pkg for the word width.

module twp_store
  import twp_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  // Write in arrival order
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/twp_seq.sv]
// Load/count/emit sequencer with the output register of the partition unit.
// Depends on twp_pkg; drives the ports of twp_store.

module twp_seq
  import twp_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_W-1:0]    pivot,
  // input words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_W-1:0]    s_axis_tdata,
  input  logic                  s_axis_tlast,
  // element store ports
  output logic                  mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [VALUE_W-1:0]    mem_wdata,
  output logic                  mem_re,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  input  logic [VALUE_W-1:0]    mem_rdata,
  // result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [REGION_W-1:0]   m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > TOTAL_W) ? CW : TOTAL_W;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COUNT,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [XW-1:0]      fill;
  logic               ovf;
  logic [XW-1:0]      iss;
  logic               rd_vld;
  region_t            cls;
  logic [XW-1:0]      pos;
  logic [XW-1:0]      small_cnt;
  logic [XW-1:0]      equal_cnt;

  // output register
  logic                  out_vld;
  logic [VALUE_W-1:0]    out_value;
  region_t               out_region;
  logic [POSITION_W-1:0] out_pos;
  logic [TOTAL_W-1:0]    out_small;
  logic [TOTAL_W-1:0]    out_equal;
  logic                  out_ovf;
  logic                  out_end;

  logic    accept;
  logic    has_room;
  region_t rd_cls;
  logic    out_free;
  logic    match;
  logic    consume;
  logic    issue;
  logic    pass_done;
  logic    emit;

  // Handshake and pass control
  always_comb begin
    accept    = s_axis_tvalid && s_axis_tready;
    has_room  = (fill != XW'(CAPACITY));
    rd_cls    = classify(mem_rdata, pivot);
    out_free  = !out_vld || m_axis_tready;
    match     = (rd_cls == cls);
    consume   = rd_vld && ((state == ST_COUNT) || !match || out_free);
    issue     = (state != ST_LOAD) && (iss != fill) && (!rd_vld || consume);
    pass_done = (state != ST_LOAD) && (iss == fill) && (!rd_vld || consume);
    emit      = (state == ST_EMIT) && consume && match;
  end

  assign s_axis_tready = (state == ST_LOAD);

  // Store accesses: write on load, one read per issued index
  assign mem_we    = accept && has_room;
  assign mem_waddr = fill[AW-1:0];
  assign mem_wdata = s_axis_tdata;
  assign mem_re    = issue;
  assign mem_raddr = iss[AW-1:0];

  // State, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      fill      <= '0;
      ovf       <= 1'b0;
      iss       <= '0;
      rd_vld    <= 1'b0;
      cls       <= REGION_SMALLER;
      pos       <= '0;
      small_cnt <= '0;
      equal_cnt <= '0;
      out_vld   <= 1'b0;
    end else begin
      // load a new result, or drop a taken one
      if (emit) begin
        out_vld    <= 1'b1;
        out_value  <= mem_rdata;
        out_region <= cls;
        out_pos    <= pos[POSITION_W-1:0];
        out_small  <= small_cnt[TOTAL_W-1:0];
        out_equal  <= equal_cnt[TOTAL_W-1:0];
        out_ovf    <= ovf;
        out_end    <= ((pos + XW'(1)) == fill);
      end else if (m_axis_tready) begin
        out_vld <= 1'b0;
      end

      // track the read in flight
      if (issue) begin
        rd_vld <= 1'b1;
        iss    <= iss + XW'(1);
      end else if (consume) begin
        rd_vld <= 1'b0;
      end

      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (has_room) begin
              fill <= fill + XW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_axis_tlast) begin
              state     <= ST_COUNT;
              iss       <= '0;
              small_cnt <= '0;
              equal_cnt <= '0;
            end
          end
        end
        ST_COUNT: begin
          if (consume) begin
            if (rd_cls == REGION_SMALLER) begin
              small_cnt <= small_cnt + XW'(1);
            end else if (rd_cls == REGION_EQUAL) begin
              equal_cnt <= equal_cnt + XW'(1);
            end
          end
          if (pass_done) begin
            state <= ST_EMIT;
            cls   <= REGION_SMALLER;
            iss   <= '0;
            pos   <= '0;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            pos <= pos + XW'(1);
          end
          if (pass_done) begin
            iss <= '0;
            case (cls)
              REGION_SMALLER: cls <= REGION_EQUAL;
              REGION_EQUAL:   cls <= REGION_BIGGER;
              default: begin
                state <= ST_LOAD;
                fill  <= '0;
                ovf   <= 1'b0;
                cls   <= REGION_SMALLER;
              end
            endcase
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {1'b0, out_ovf, out_equal, out_small, out_pos, out_value};
  assign m_axis_tuser  = out_region;
  assign m_axis_tlast  = out_end;

endmodule

[design/three_way_pivot_partition_unit.sv]
// Throughput: words load at one per cycle while the unit is in its load state. After the final
// word the unit makes four passes (count, then one per class) over the N stored elements and
// takes no new word until the last pass is done. The first result is registered in the first
// class pass that finds an element of its class.
// Reset: rst (synchronous) clears pivot, fill count, overflow flag and valids;
// store contents are left as they are.

module three_way_pivot_partition_unit
  import twp_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // pivot register
  input  logic                  cfg_we,
  input  logic [VALUE_W-1:0]    cfg_wdata,
  // input words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_W-1:0]    s_axis_tdata,   // [31:0] element_value
  input  logic                  s_axis_tlast,   // is_final
  // result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] out_value, [35:32] position,
                                                // [40:36] smaller_total,
                                                // [45:41] equal_total,
                                                // [46] overflowed, [47] zero
  output logic [REGION_W-1:0]   m_axis_tuser,   // [1:0] region
  output logic                  m_axis_tlast    // run_end
);

  localparam int AW = $clog2(CAPACITY);

  logic [VALUE_W-1:0] pivot;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  // Hold the pivot register
  always_ff @(posedge clk) begin
    if (rst) begin
      pivot <= '0;
    end else if (cfg_we) begin
      pivot <= cfg_wdata;
    end
  end

  twp_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  twp_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .pivot         (pivot),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Come out of reset empty and ready to load
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("unit not idle after reset");

  // Stop loading once the final word is taken
  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still accepted after final word");

  // Regions never go backward within a run
  a_region_order: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (!m_axis_tvalid || (m_axis_tuser >= $past(m_axis_tuser))))
    else $error("region order broken within a run");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for three_way_pivot_partition_unit: streams signed words in, predicts
// the stable three-way partition of every run and checks each result word in order.
// Depends on twp_pkg and the unit itself.

module tb_top;
  import twp_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int DRAIN_CYCLES  = 4 * (CAPACITY + 1) + 16;
  localparam int PHASE_WORDS   = 62;
  localparam int LONG_HOLD     = 500;
  localparam int HOLD_AFTER    = 40;

  // One expected result word
  typedef struct {
    logic [VALUE_W-1:0]    value;
    region_t               region;
    logic [POSITION_W-1:0] position;
    logic [TOTAL_W-1:0]    smaller_total;
    logic [TOTAL_W-1:0]    equal_total;
    logic                  overflowed;
    logic                  run_end;
  } part_result_t;

  // Mirror of the unit: holds pivot, stored run and the partitioned words still due
  class partition_scoreboard;
    logic [VALUE_W-1:0] pivot;
    logic [VALUE_W-1:0] run_store [CAPACITY];
    int                 fill;
    bit                 dropped;
    part_result_t       partitioned_q [$];
    int                 checked;
    int                 errors;

    function new();
      pivot   = '0;
      fill    = 0;
      dropped = 0;
      checked = 0;
      errors  = 0;
    endfunction

    function void set_pivot(logic [VALUE_W-1:0] p);
      pivot = p;
    endfunction

    function int pending();
      return partitioned_q.size();
    endfunction

    function region_t region_of(logic [VALUE_W-1:0] v);
      if ($signed(v) < $signed(pivot)) return REGION_SMALLER;
      if (v == pivot) return REGION_EQUAL;
      return REGION_BIGGER;
    endfunction

    // Queue every stored word of one class, in arrival order
    function void emit_class(region_t cls, int n_small, int n_equal, inout int pos);
      part_result_t r;
      for (int i = 0; i < fill; i++) begin
        if (region_of(run_store[i]) == cls) begin
          r.value         = run_store[i];
          r.region        = cls;
          r.position      = pos[POSITION_W-1:0];
          r.smaller_total = n_small[TOTAL_W-1:0];
          r.equal_total   = n_equal[TOTAL_W-1:0];
          r.overflowed    = dropped;
          r.run_end       = (pos + 1 == fill);
          partitioned_q.push_back(r);
          pos++;
        end
      end
    endfunction

    // Store an accepted input word; on the final word predict the whole partition
    function void note_word(logic [VALUE_W-1:0] v, logic fin);
      int n_small;
      int n_equal;
      int pos;
      if (fill < CAPACITY) begin
        run_store[fill] = v;
        fill++;
      end else begin
        dropped = 1;
      end
      if (!fin) return;
      n_small = 0;
      n_equal = 0;
      pos     = 0;
      for (int i = 0; i < fill; i++) begin
        case (region_of(run_store[i]))
          REGION_SMALLER: n_small++;
          REGION_EQUAL:   n_equal++;
          default: ;
        endcase
      end
      emit_class(REGION_SMALLER, n_small, n_equal, pos);
      emit_class(REGION_EQUAL, n_small, n_equal, pos);
      emit_class(REGION_BIGGER, n_small, n_equal, pos);
      fill    = 0;
      dropped = 0;
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one accepted result word with the oldest prediction
    function void check_word(logic [OUT_DATA_W-1:0] data, logic [REGION_W-1:0] user,
                             logic last);
      part_result_t e;
      checked++;
      if (partitioned_q.size() == 0) begin
        $error("result word with nothing expected: data %h region %h last %b",
               data, user, last);
        errors++;
        return;
      end
      e = partitioned_q.pop_front();
      compare_field("out_value", e.value, data[31:0]);
      compare_field("region", 32'(e.region), 32'(user));
      compare_field("position", 32'(e.position), 32'(data[35:32]));
      compare_field("smaller_total", 32'(e.smaller_total), 32'(data[40:36]));
      compare_field("equal_total", 32'(e.equal_total), 32'(data[45:41]));
      compare_field("overflowed", 32'(e.overflowed), 32'(data[46]));
      compare_field("pad", 32'd0, 32'(data[47]));
      compare_field("run_end", 32'(e.run_end), 32'(last));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [VALUE_W-1:0]    cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [VALUE_W-1:0]    s_axis_tdata;   // [31:0] element_value
  logic                  s_axis_tlast;   // is_final
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [31:0] out_value, [35:32] position,
                                         // [40:36] smaller_total, [45:41] equal_total,
                                         // [46] overflowed, [47] zero
  logic [REGION_W-1:0]   m_axis_tuser;   // [1:0] region
  logic                  m_axis_tlast;   // run_end

  partition_scoreboard sb;
  bit                  sender_calm;

  three_way_pivot_partition_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock, 10 ns period
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values near the pivot, the extremes, small numbers and noise
  function automatic logic [VALUE_W-1:0] pick_value(logic [VALUE_W-1:0] p);
    case ($urandom_range(0, 9))
      0, 1:    return p;
      2:       return p + 1;
      3:       return p - 1;
      4:       return 32'h8000_0000;
      5:       return 32'h7fff_ffff;
      6:       return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word after a random gap (none while the sender is calm) and hold it until accepted
  task automatic send_word(input logic [VALUE_W-1:0] v, input logic fin);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(v, fin);
  endtask

  // Drop valid and wait until every predicted word has come out, then let the unit settle
  task automatic drain_unit();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pivot(input logic [VALUE_W-1:0] p);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_pivot(p);
  endtask

  // Random runs, some past capacity, until the phase budget is spent
  task automatic random_phase(input logic [VALUE_W-1:0] p);
    int sent;
    int len;
    sent = 0;
    while (sent < PHASE_WORDS) begin
      len         = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22)
                                                : $urandom_range(1, 16);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        send_word(pick_value(p), i == len - 1);
      end
      sent += len;
    end
    sender_calm = 0;
  endtask

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int  stall_left;
    int  g;
    bit  calm;
    bit  held;
    stall_left    = 0;
    calm          = 0;
    held          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      if ($urandom_range(0, 149) == 0) calm = !calm;
      if (!held && sb.checked >= HOLD_AFTER) begin
        held       = 1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        g = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (g > 0) begin
          stall_left    = g - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("[three_way_pivot_partition_unit] ERROR");
    $finish;
  end

  // Main sequence
  initial begin
    logic [VALUE_W-1:0] pivots [6];
    logic [VALUE_W-1:0] v;
    sb            = new();
    sender_calm   = 0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, pivot at its reset value: single-word run at the minimum
    send_word(32'h8000_0000, 1'b1);
    // All three classes, with the largest value
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    // Fill past capacity: two words dropped, the final one among them
    for (int i = 0; i < CAPACITY + 2; i++) begin
      v = (i % 3 == 0) ? 32'hffff_ffff : (i % 3 == 1) ? 32'h0 : 32'(i);
      send_word(v, i == CAPACITY + 1);
    end
    drain_unit();

    // Random phases over several pivots, the extremes among them
    pivots[0] = 32'h0000_0000;
    pivots[1] = 32'h8000_0000;
    pivots[2] = 32'h7fff_ffff;
    pivots[3] = $urandom;
    pivots[4] = $urandom_range(0, 4) - 2;
    pivots[5] = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      write_pivot(pivots[ph]);
      random_phase(pivots[ph]);
      drain_unit();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[three_way_pivot_partition_unit] OK");
    end else begin
      $display("[three_way_pivot_partition_unit] ERROR");
    end
    $finish;
  end

endmodule
